@@ sv/npcm_pkg.sv @@
// Shared types and constants for the nearest palette color map.
package npcm_pkg;

  localparam int unsigned IDX_W   = 8;
  localparam int unsigned COLOR_W = 8;
  localparam int unsigned SQ_W    = 2 * COLOR_W;
  localparam int unsigned DIST_W  = 18;

  // Item kinds on the input channel.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [COLOR_W-1:0] chan_t;
  typedef logic [SQ_W-1:0]    sq_t;
  typedef logic [DIST_W-1:0]  dist_t;

  typedef struct packed {
    chan_t red;
    chan_t green;
    chan_t blue;
  } rgb_t;

  // One palette entry travelling with its index through the distance unit.
  typedef struct packed {
    idx_t idx;
    rgb_t color;
  } cand_t;

endpackage

@@ sv/npcm_ifs.sv @@
// Channel interfaces for the nearest palette color map.
interface npcm_in_if
  import npcm_pkg::*;
();
  logic  valid;
  logic  ready;
  logic  kind;
  idx_t  entry_index;
  chan_t red_in;
  chan_t green_in;
  chan_t blue_in;

  modport source (output valid, kind, entry_index, red_in, green_in, blue_in,
                  input ready);
  modport sink   (input valid, kind, entry_index, red_in, green_in, blue_in,
                  output ready);
endinterface

interface npcm_out_if
  import npcm_pkg::*;
();
  logic  valid;
  logic  ready;
  idx_t  match_index;
  chan_t red_out;
  chan_t green_out;
  chan_t blue_out;
  logic  exact_hit;
  dist_t distance;

  modport source (output valid, match_index, red_out, green_out, blue_out,
                  exact_hit, distance, input ready);
  modport sink   (input valid, match_index, red_out, green_out, blue_out,
                  exact_hit, distance, output ready);
endinterface

@@ sv/npcm_dist.sv @@
// Pipelined squared RGB distance unit, reused for every scanned entry.
module npcm_dist
  import npcm_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  active,
  input  logic  in_vld,
  input  cand_t in_cand,
  input  rgb_t  query,
  output logic  out_vld,
  output cand_t out_cand,
  output dist_t out_dist
);

  logic  v1_r, v2_r, v3_r;
  cand_t c1_r, c2_r, c3_r;
  chan_t dr_r, dg_r, db_r;
  sq_t   sr_r, sg_r, sb_r;
  dist_t sum_r;

  function automatic chan_t abs_diff(input chan_t a, input chan_t b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // Valid bits; they are cleared while the scan is not active, so they empty once the scan stops.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld && active;
      v2_r <= v1_r && active;
      v3_r <= v2_r && active;
    end
  end

  // Stage one takes absolute differences, stage two squares them, stage three sums.
  always_ff @(posedge clk) begin
    c1_r  <= in_cand;
    dr_r  <= abs_diff(query.red,   in_cand.color.red);
    dg_r  <= abs_diff(query.green, in_cand.color.green);
    db_r  <= abs_diff(query.blue,  in_cand.color.blue);
    c2_r  <= c1_r;
    sr_r  <= SQ_W'(dr_r) * SQ_W'(dr_r);
    sg_r  <= SQ_W'(dg_r) * SQ_W'(dg_r);
    sb_r  <= SQ_W'(db_r) * SQ_W'(db_r);
    c3_r  <= c2_r;
    sum_r <= DIST_W'(sr_r) + DIST_W'(sg_r) + DIST_W'(sb_r);
  end

  assign out_vld  = v3_r;
  assign out_cand = c3_r;
  assign out_dist = sum_r;

endmodule

@@ sv/nearest_palette_color_map.sv @@
// A load word is written into the palette as it is accepted, so loads can follow back to back.
// A query equal to its own entry goes from the entry check straight to the output stage; else the
// scan reads one entry per cycle through a registered read and a three-stage distance unit,
// and stops at the first entry with distance zero or at the last entry within the scan limit.
// The next word can be taken in the cycle after the result loads, and a result waiting for
// out_word.ready holds the block. Reset clears the sequencer, the valid bits and the best-found flag only.
module nearest_palette_color_map
  import npcm_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256,
  parameter int unsigned SEARCH_LIMIT    = 255
) (
  input logic        clk,
  input logic        rst_n,
  npcm_in_if.sink    in_word,
  npcm_out_if.source out_word
);

  localparam int unsigned AW    = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam int unsigned LIMIT = (SEARCH_LIMIT < PALETTE_ENTRIES) ? SEARCH_LIMIT
                                                                   : PALETTE_ENTRIES;
  localparam int unsigned CW    = AW + 1;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CHK  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  rgb_t          q_r, q_nxt;
  idx_t          qidx_r, qidx_nxt;
  logic          qin_r, qin_nxt;
  idx_t          best_idx_r, best_idx_nxt;
  rgb_t          best_rgb_r, best_rgb_nxt;
  dist_t         best_dist_r, best_dist_nxt;
  logic          best_ok_r, best_ok_nxt;
  logic          exact_r, exact_nxt;
  logic          out_valid_r, out_valid_nxt;
  idx_t          out_idx_r;
  rgb_t          out_rgb_r;
  dist_t         out_dist_r;
  logic          out_exact_r;

  rgb_t          pal_mem [PALETTE_ENTRIES];
  rgb_t          rd_data_r;
  logic [AW-1:0] rd_addr;
  logic          rd_vld_r, issue;
  idx_t          rd_idx_r;
  cand_t         rd_cand;

  logic          accept, in_range, out_load;
  rgb_t          in_rgb;
  logic          d_vld;
  cand_t         d_cand;
  dist_t         d_dist;
  logic          better, stop;

  assign in_word.ready = (state_r == S_IDLE);
  assign accept        = in_word.valid && in_word.ready;
  assign in_rgb        = '{red: in_word.red_in, green: in_word.green_in,
                           blue: in_word.blue_in};
  assign in_range      = ({1'b0, in_word.entry_index} < (IDX_W + 1)'(PALETTE_ENTRIES));

  // Palette memory: one write and one registered read per cycle.
  assign rd_addr = (state_r == S_IDLE) ? in_word.entry_index[AW-1:0] : cnt_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (accept && in_word.kind == KIND_LOAD && in_range) begin
      pal_mem[in_word.entry_index[AW-1:0]] <= in_rgb;
    end
    rd_data_r <= pal_mem[rd_addr];
    rd_idx_r  <= IDX_W'(cnt_r);
  end

  assign rd_cand = '{idx: rd_idx_r, color: rd_data_r};

  // Shared distance pipeline fed by the read data.
  npcm_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .active   (state_r == S_SCAN),
    .in_vld   (rd_vld_r),
    .in_cand  (rd_cand),
    .query    (q_r),
    .out_vld  (d_vld),
    .out_cand (d_cand),
    .out_dist (d_dist)
  );

  // Only a strictly smaller distance replaces the best, so the first entry wins a tie.
  assign better = d_vld && (!best_ok_r || d_dist < best_dist_r);
  assign stop   = d_vld && ((better && d_dist == '0) || d_cand.idx == IDX_W'(LIMIT - 1));
  assign issue  = (state_r == S_SCAN) && (cnt_r < CW'(LIMIT)) && !stop;
  assign out_load = (state_r == S_FIN) && (!out_valid_r || out_word.ready);

  // Sequencer: entry check, then the scan unless the entry matches, then hand-off to the output register.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    q_nxt         = q_r;
    qidx_nxt      = qidx_r;
    qin_nxt       = qin_r;
    best_idx_nxt  = best_idx_r;
    best_rgb_nxt  = best_rgb_r;
    best_dist_nxt = best_dist_r;
    best_ok_nxt   = best_ok_r;
    exact_nxt     = exact_r;
    out_valid_nxt = out_valid_r && !out_word.ready;
    case (state_r)
      S_IDLE: begin
        if (accept && in_word.kind == KIND_QUERY) begin
          q_nxt     = in_rgb;
          qidx_nxt  = in_word.entry_index;
          qin_nxt   = in_range;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (qin_r && rd_data_r == q_r) begin
          best_idx_nxt  = qidx_r;
          best_rgb_nxt  = q_r;
          best_dist_nxt = '0;
          exact_nxt     = 1'b1;
          state_nxt     = S_FIN;
        end else begin
          best_ok_nxt = 1'b0;
          exact_nxt   = 1'b0;
          cnt_nxt     = '0;
          state_nxt   = S_SCAN;
        end
      end
      S_SCAN: begin
        if (issue) begin
          cnt_nxt = cnt_r + 1'b1;
        end
        if (better) begin
          best_idx_nxt  = d_cand.idx;
          best_rgb_nxt  = d_cand.color;
          best_dist_nxt = d_dist;
          best_ok_nxt   = 1'b1;
        end
        if (stop) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      rd_vld_r    <= 1'b0;
      best_ok_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rd_vld_r    <= issue;
      best_ok_r   <= best_ok_nxt;
    end
  end

  // Query and result payload registers.
  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    q_r         <= q_nxt;
    qidx_r      <= qidx_nxt;
    qin_r       <= qin_nxt;
    best_idx_r  <= best_idx_nxt;
    best_rgb_r  <= best_rgb_nxt;
    best_dist_r <= best_dist_nxt;
    exact_r     <= exact_nxt;
    if (out_load) begin
      out_idx_r   <= best_idx_r;
      out_rgb_r   <= best_rgb_r;
      out_dist_r  <= best_dist_r;
      out_exact_r <= exact_r;
    end
  end

  assign out_word.valid       = out_valid_r;
  assign out_word.match_index = out_idx_r;
  assign out_word.red_out     = out_rgb_r.red;
  assign out_word.green_out   = out_rgb_r.green;
  assign out_word.blue_out    = out_rgb_r.blue;
  assign out_word.exact_hit   = out_exact_r;
  assign out_word.distance    = out_dist_r;

endmodule
